>>> design/assert_macros.svh
// Assertion macros for the RTL of the fixed-point ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/fpa_pkg.sv
// Package with the widths, codes and types of the fixed-point ALU.
package fpa_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int OP_W      = 4;
  localparam int STAT_W    = 2;

  localparam int NUM_W      = WORD_W + FRAC_BITS;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_PAD_W  = DIV_STAGES * DIV_BITS;
  localparam int DIV_Q_W    = DIV_PAD_W + 1;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int MULQ_W     = PROD_W - FRAC_BITS;
  localparam int MAG_W      = (MULQ_W > DIV_Q_W) ? MULQ_W : DIV_Q_W;
  localparam int NSTG       = DIV_STAGES + 3;
  localparam int MULQ_STAGE = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
  localparam logic [PROD_W-1:0] MUL_RND = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_CMP = 4'd8
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    op_e                 op;
    word_t               res;
    logic                ovf;
    logic                lt;
    logic                eq;
    logic                gt;
    logic                neg;
    logic                dz;
    logic [MULQ_W-1:0]   mulq;
  } side_t;

endpackage

>>> design/fpa_req_if.sv
// Request channel of the fixed-point ALU.
interface fpa_req_if import fpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          req_type;
  logic signed [WORD_W-1:0] operand_a;
  logic signed [WORD_W-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

>>> design/fpa_rsp_if.sv
// Result channel of the fixed-point ALU.
interface fpa_rsp_if import fpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result_raw;
  logic                     a_less;
  logic                     a_equal;
  logic                     a_greater;
  logic [STAT_W-1:0]        status_code;

  modport source (output valid, result_raw, a_less, a_equal, a_greater, status_code,
                  input ready);
  modport sink (input valid, result_raw, a_less, a_equal, a_greater, status_code,
                output ready);
endinterface

>>> design/fpa_div.sv
// Pipelined restoring divider for the scaled magnitude quotient.
module fpa_div import fpa_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  word_t                 num_i,
  input  word_t                 den_i,
  output logic [DIV_PAD_W-1:0]  quo_o,
  output word_t                 rem_o,
  output word_t                 den_o
);

  typedef struct packed {
    word_t                rem;
    logic [DIV_PAD_W-1:0] nq;
  } dstate_t;

  function automatic dstate_t div_step(dstate_t s, word_t d);
    dstate_t         r;
    logic [WORD_W:0] trial;
    r = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r.rem, r.nq[DIV_PAD_W-1]};
      r.nq  = {r.nq[DIV_PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        r.rem   = WORD_W'(trial - {1'b0, d});
        r.nq[0] = 1'b1;
      end else begin
        r.rem = trial[WORD_W-1:0];
      end
    end
    return r;
  endfunction

  word_t                rem_q [DIV_STAGES];
  logic [DIV_PAD_W-1:0] nq_q  [DIV_STAGES];
  word_t                den_q [DIV_STAGES];
  logic [DIV_PAD_W-1:0] nq_in;

  assign nq_in = DIV_PAD_W'({num_i, {FRAC_BITS{1'b0}}});

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    dstate_t cur;
    dstate_t nxt;
    word_t   d_cur;

    if (s == 0) begin : g_first
      assign cur   = {word_t'(0), nq_in};
      assign d_cur = den_i;
    end else begin : g_rest
      assign cur   = {rem_q[s-1], nq_q[s-1]};
      assign d_cur = den_q[s-1];
    end

    assign nxt = div_step(cur, d_cur);

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= nxt.rem;
        nq_q[s]  <= nxt.nq;
        den_q[s] <= d_cur;
      end
    end
  end

  assign quo_o = nq_q[DIV_STAGES-1];
  assign rem_o = rem_q[DIV_STAGES-1];
  assign den_o = den_q[DIV_STAGES-1];

endmodule

>>> design/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU: one request per cycle unless the pipeline is full and stalled; its stages
// run from the request transfer to the result being offered (ten divider stages of four quotient bits each,
// an input stage, a rounding stage and the output register). Results leave in request order;
// when the result side stalls, empty stages still fill, and requests are refused only once
// every stage holds a request. Every result carries the comparison flags of its operands.
`include "assert_macros.svh"

module fixed_point_q24_8_alu import fpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] valid_d;
  logic [NSTG:0]   rdy;

  op_e             op_in;
  word_t           a_in;
  word_t           b_in;
  word_t           y_in;
  logic            cin;
  logic [WORD_W:0] sum;
  side_t           side0_d;

  side_t           side_q [NSTG-1];
  word_t           maga_q;
  word_t           magb_q;
  logic [PROD_W-1:0] prod_q;

  logic [DIV_PAD_W-1:0] quo;
  word_t                rem;
  word_t                dden;
  logic                 div_rnd;
  logic [MAG_W-1:0]     mag_d;
  logic [MAG_W-1:0]     mag_q;

  side_t            last;
  logic [MAG_W-1:0] limit;
  logic             big;
  word_t            fin;
  word_t            res_d;
  word_t            res_q;
  status_e          st_d;
  status_e          st_q;
  logic             lt_q;
  logic             eq_q;
  logic             gt_q;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[NSTG] = rsp_o.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign valid_d     = {valid_q[NSTG-2:0], req_i.valid};
  assign req_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  always_comb begin
    op_in = op_e'(req_i.req_type);
    a_in  = req_i.operand_a;
    b_in  = req_i.operand_b;
    cin   = 1'b0;
    case (op_in)
      OP_SUB: begin
        y_in = ~b_in;
        cin  = 1'b1;
      end
      OP_INC:  y_in = WORD_W'(1);
      OP_DEC:  y_in = '1;
      default: y_in = b_in;
    endcase
    sum = {a_in[WORD_W-1], a_in} + {y_in[WORD_W-1], y_in} + (WORD_W + 1)'(cin);

    side0_d     = '0;
    side0_d.op  = op_in;
    side0_d.lt  = $signed(a_in) < $signed(b_in);
    side0_d.eq  = a_in == b_in;
    side0_d.gt  = $signed(a_in) > $signed(b_in);
    side0_d.neg = a_in[WORD_W-1] ^ b_in[WORD_W-1];
    side0_d.dz  = b_in == '0;
    case (op_in)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum[WORD_W] != sum[WORD_W-1]) begin
          side0_d.ovf = 1'b1;
          side0_d.res = a_in[WORD_W-1] ? WORD_MIN : WORD_MAX;
        end else begin
          side0_d.res = sum[WORD_W-1:0];
        end
      end
      OP_MIN:  side0_d.res = side0_d.lt ? a_in : b_in;
      OP_MAX:  side0_d.res = side0_d.gt ? a_in : b_in;
      default: side0_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      side_q[0] <= side0_d;
      maga_q    <= a_in[WORD_W-1] ? word_t'(-a_in) : a_in;
      magb_q    <= b_in[WORD_W-1] ? word_t'(-b_in) : b_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      prod_q <= PROD_W'(maga_q) * PROD_W'(magb_q);
    end
  end

  for (genvar k = 1; k < NSTG - 1; k++) begin : g_side
    side_t side_d;

    if (k == MULQ_STAGE) begin : g_mulq
      logic [PROD_W-1:0] rounded;
      assign rounded = prod_q + MUL_RND;
      always_comb begin
        side_d      = side_q[k-1];
        side_d.mulq = rounded[PROD_W-1:FRAC_BITS];
      end
    end else begin : g_copy
      assign side_d = side_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        side_q[k] <= side_d;
      end
    end
  end

  fpa_div u_div (
    .clk_i (clk_i),
    .en_i  (rdy[DIV_STAGES:1]),
    .num_i (maga_q),
    .den_i (magb_q),
    .quo_o (quo),
    .rem_o (rem),
    .den_o (dden)
  );

  always_comb begin
    div_rnd = {rem, 1'b0} >= {1'b0, dden};
    if (side_q[NSTG-3].op == OP_MUL) begin
      mag_d = MAG_W'(side_q[NSTG-3].mulq);
    end else begin
      mag_d = MAG_W'(quo) + MAG_W'(div_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-2]) begin
      mag_q <= mag_d;
    end
  end

  always_comb begin
    last  = side_q[NSTG-2];
    limit = last.neg ? MAG_W'(WORD_MIN) : MAG_W'(WORD_MAX);
    big   = mag_q > limit;
    if (big) begin
      fin = last.neg ? WORD_MIN : WORD_MAX;
    end else begin
      fin = last.neg ? word_t'(-mag_q[WORD_W-1:0]) : mag_q[WORD_W-1:0];
    end
    case (last.op)
      OP_MUL: begin
        res_d = fin;
        st_d  = big ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (last.dz) begin
          res_d = '0;
          st_d  = ST_DIVZ;
        end else begin
          res_d = fin;
          st_d  = big ? ST_OVF : ST_OK;
        end
      end
      default: begin
        res_d = last.res;
        st_d  = last.ovf ? ST_OVF : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-1]) begin
      res_q <= res_d;
      st_q  <= st_d;
      lt_q  <= last.lt;
      eq_q  <= last.eq;
      gt_q  <= last.gt;
    end
  end

  assign rsp_o.valid       = valid_q[NSTG-1];
  assign rsp_o.result_raw  = res_q;
  assign rsp_o.a_less      = lt_q;
  assign rsp_o.a_equal     = eq_q;
  assign rsp_o.a_greater   = gt_q;
  assign rsp_o.status_code = st_q;

  `ASSERT_NXT(a_enter, clk_i, rst_ni, req_i.valid && req_i.ready, valid_q[0])
  `ASSERT_IMP(a_full_stall, clk_i, rst_ni, !req_i.ready, (&valid_q) && !rsp_o.ready)
  `ASSERT_IMP(a_flags, clk_i, rst_ni, rsp_o.valid, $onehot({lt_q, eq_q, gt_q}))
  `ASSERT_IMP(a_divz, clk_i, rst_ni, rsp_o.valid && st_q == ST_DIVZ, res_q == '0)
  `ASSERT_IMP(a_sat, clk_i, rst_ni, rsp_o.valid && st_q == ST_OVF,
              res_q == WORD_MAX || res_q == WORD_MIN)

endmodule
